FILE: rtl/core/nsg_pkg.sv
// Shared types, formats and rounding helpers for the near segment gate.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package nsg_pkg;

    // Fixed-point formats
    localparam int COORD_FRAC_BITS = 10;
    localparam int QUAT_FRAC       = 14;
    localparam int VEH_FRAC        = 8;
    localparam int MU_FRAC         = 16;
    localparam int VEH_SHIFT       = COORD_FRAC_BITS + QUAT_FRAC - VEH_FRAC;

    // Signal widths
    localparam int CW   = 32;   // map coordinate
    localparam int QW   = 16;   // quaternion component
    localparam int DW   = 33;   // map minus pose
    localparam int RW   = 21;   // rotation entry
    localparam int PW   = 54;   // rotation times offset
    localparam int AW   = 56;   // sum of three products
    localparam int VW   = 22;   // vehicle-frame coordinate
    localparam int TW   = 23;   // tangent component
    localparam int SW   = 48;   // squared length, inner product, remainder
    localparam int MUW  = 17;   // mu including the value one
    localparam int NW   = 25;   // nearest point coordinate

    localparam logic signed [AW-1:0] VEH_LIMIT = AW'(2097151);

    // Squared length below 0.001 m^2 in 2^-16 m^2 units
    localparam logic [SW-1:0] DEGEN_LIMIT = SW'(66);

    // Gate constants
    localparam logic [63:0] GATE_LAT2  = 64'(10 * 10);
    localparam logic [63:0] GATE_LONG2 = 64'(60 * 60);
    localparam logic [63:0] GATE_RHS   = 64'(60 * 60 * 10 * 10) << (2 * VEH_FRAC);

    // Configuration register indexes
    localparam logic [2:0] REG_QUAT_W = 3'd0;
    localparam logic [2:0] REG_QUAT_X = 3'd1;
    localparam logic [2:0] REG_QUAT_Y = 3'd2;
    localparam logic [2:0] REG_QUAT_Z = 3'd3;
    localparam logic [2:0] REG_POS_X  = 3'd4;
    localparam logic [2:0] REG_POS_Y  = 3'd5;
    localparam logic [2:0] REG_POS_Z  = 3'd6;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [QW-1:0] t_quat;
    typedef logic signed [VW-1:0] t_veh;
    typedef logic signed [TW-1:0] t_tan;

    // Request leaving the projection stages toward the divider
    typedef struct packed {
        t_veh              a0;
        t_veh              a1;
        t_tan              t0;
        t_tan              t1;
        logic [SW-1:0]     tsq;
        logic [SW-1:0]     rem;
        logic [MU_FRAC-1:0] q;
        logic              degen;
        logic              full;
    } t_div_item;

    // Round a rotation entry from scale 2^28 to Q.14, half up
    function automatic logic signed [RW-1:0] rnd_q14(input logic signed [35:0] e);
        logic signed [35:0] s;
        s = (e + 36'sd8192) >>> QUAT_FRAC;
        return s[RW-1:0];
    endfunction

    // Round to the vehicle-frame unit, half up, and saturate
    function automatic t_veh veh_round(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] s;
        s = (acc + (AW'(1) <<< (VEH_SHIFT - 1))) >>> VEH_SHIFT;
        if (s > VEH_LIMIT) begin
            s = VEH_LIMIT;
        end else if (s < -VEH_LIMIT) begin
            s = -VEH_LIMIT;
        end
        return s[VW-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nsg_xform.sv
// Map-to-vehicle transform: four stages from raw endpoints to rotated coordinates.
// Depends on nsg_pkg.
`default_nettype none

module nsg_xform (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  nsg_pkg::t_coord     i_from [3],
    input  nsg_pkg::t_coord     i_to   [3],
    input  nsg_pkg::t_quat      i_quat [4],
    input  nsg_pkg::t_coord     i_pos  [3],
    output logic                o_valid,
    output nsg_pkg::t_veh       o_a    [3],
    output nsg_pkg::t_veh       o_b    [3]
);
    import nsg_pkg::*;

    logic [3:0]              r_v;
    logic signed [DW-1:0]    r_df1 [3];
    logic signed [DW-1:0]    r_dt1 [3];
    logic signed [DW-1:0]    r_df2 [3];
    logic signed [DW-1:0]    r_dt2 [3];
    logic signed [31:0]      r_qp  [9];
    logic signed [RW-1:0]    r_rot [3][3];
    logic signed [PW-1:0]    r_pf  [3][3];
    logic signed [PW-1:0]    r_pt  [3][3];
    logic signed [RW-1:0]    n_rot [3][3];
    logic signed [35:0]      qe    [9];

    // Valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end
    assign o_valid = r_v[3];

    // Products are ordered xx, yy, zz, xy, xz, yz, wx, wy, wz
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            qe[k] = 36'(r_qp[k]);
        end
        n_rot[0][0] = rnd_q14(36'sh10000000 - ((qe[1] + qe[2]) <<< 1));
        n_rot[0][1] = rnd_q14((qe[3] - qe[8]) <<< 1);
        n_rot[0][2] = rnd_q14((qe[4] + qe[7]) <<< 1);
        n_rot[1][0] = rnd_q14((qe[3] + qe[8]) <<< 1);
        n_rot[1][1] = rnd_q14(36'sh10000000 - ((qe[0] + qe[2]) <<< 1));
        n_rot[1][2] = rnd_q14((qe[5] - qe[6]) <<< 1);
        n_rot[2][0] = rnd_q14((qe[4] - qe[7]) <<< 1);
        n_rot[2][1] = rnd_q14((qe[5] + qe[6]) <<< 1);
        n_rot[2][2] = rnd_q14(36'sh10000000 - ((qe[0] + qe[1]) <<< 1));
    end

    // Stage 1: offsets from the pose and quaternion products
    // Stage 2: rotation entries
    // Stage 3: rotation times offsets
    // Stage 4: sums, rounding and saturation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_df1[i] <= DW'(i_from[i]) - DW'(i_pos[i]);
                r_dt1[i] <= DW'(i_to[i]) - DW'(i_pos[i]);
            end
            r_qp[0] <= i_quat[1] * i_quat[1];
            r_qp[1] <= i_quat[2] * i_quat[2];
            r_qp[2] <= i_quat[3] * i_quat[3];
            r_qp[3] <= i_quat[1] * i_quat[2];
            r_qp[4] <= i_quat[1] * i_quat[3];
            r_qp[5] <= i_quat[2] * i_quat[3];
            r_qp[6] <= i_quat[0] * i_quat[1];
            r_qp[7] <= i_quat[0] * i_quat[2];
            r_qp[8] <= i_quat[0] * i_quat[3];

            r_rot <= n_rot;
            r_df2 <= r_df1;
            r_dt2 <= r_dt1;

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pf[i][j] <= r_rot[j][i] * r_df2[j];
                    r_pt[i][j] <= r_rot[j][i] * r_dt2[j];
                end
            end

            for (int i = 0; i < 3; i++) begin
                o_a[i] <= veh_round(AW'(r_pf[i][0]) + AW'(r_pf[i][1]) + AW'(r_pf[i][2]));
                o_b[i] <= veh_round(AW'(r_pt[i][0]) + AW'(r_pt[i][1]) + AW'(r_pt[i][2]));
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nsg_proj.sv
// Tangent, squared length and inner product; sets up the mu division.
// Depends on nsg_pkg.
`default_nettype none

module nsg_proj (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  nsg_pkg::t_veh       i_a [3],
    input  nsg_pkg::t_veh       i_b [3],
    output logic                o_valid,
    output nsg_pkg::t_div_item  o_item
);
    import nsg_pkg::*;

    logic [1:0]             r_v;
    t_veh                   r_a1 [3];
    t_tan                   r_t1 [3];
    t_veh                   r_a2 [3];
    t_tan                   r_t2 [3];
    logic signed [45:0]     r_tt [3];
    logic signed [45:0]     r_at [3];
    logic signed [SW-1:0]   tsq_s;
    logic signed [SW-1:0]   num;
    t_div_item              n_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[0], i_valid};
            o_valid <= r_v[1];
        end
    end

    // Squared length, negated inner product and the cases of mu
    always_comb begin
        tsq_s = SW'(r_tt[0]) + SW'(r_tt[1]) + SW'(r_tt[2]);
        num   = -(SW'(r_at[0]) + SW'(r_at[1]) + SW'(r_at[2]));
        n_item       = '0;
        n_item.a0    = r_a2[0];
        n_item.a1    = r_a2[1];
        n_item.t0    = r_t2[0];
        n_item.t1    = r_t2[1];
        n_item.tsq   = tsq_s;
        n_item.degen = (tsq_s < $signed(DEGEN_LIMIT));
        if (num <= 0) begin
            n_item.rem = '0;
        end else if (num >= tsq_s) begin
            n_item.full = 1'b1;
        end else begin
            n_item.rem = num;
        end
    end

    // Stage 1: tangent; stage 2: products; stage 3: sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a1[i] <= i_a[i];
                r_t1[i] <= TW'(i_b[i]) - TW'(i_a[i]);
                r_tt[i] <= r_t1[i] * r_t1[i];
                r_at[i] <= 46'(r_a1[i]) * 46'(r_t1[i]);
            end
            r_a2   <= r_a1;
            r_t2   <= r_t1;
            o_item <= n_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nsg_div.sv
// Pipelined restoring divider for mu: one quotient bit per stage.
// Depends on nsg_pkg.
`default_nettype none

module nsg_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  nsg_pkg::t_div_item  i_item,
    output logic                o_valid,
    output nsg_pkg::t_div_item  o_item
);
    import nsg_pkg::*;

    logic [MU_FRAC-1:0] r_v;
    t_div_item          r_st [MU_FRAC];
    t_div_item          n_st [MU_FRAC];
    t_div_item          src;
    logic [SW-1:0]      rem2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[MU_FRAC-2:0], i_valid};
        end
    end
    assign o_valid = r_v[MU_FRAC-1];
    assign o_item  = r_st[MU_FRAC-1];

    // Each stage doubles the remainder and subtracts the divisor when it fits
    always_comb begin
        for (int k = 0; k < MU_FRAC; k++) begin
            src  = (k == 0) ? i_item : r_st[(k == 0) ? 0 : k - 1];
            rem2 = {src.rem[SW-2:0], 1'b0};
            n_st[k] = src;
            if (rem2 >= src.tsq) begin
                n_st[k].rem = rem2 - src.tsq;
                n_st[k].q   = {src.q[MU_FRAC-2:0], 1'b1};
            end else begin
                n_st[k].rem = rem2;
                n_st[k].q   = {src.q[MU_FRAC-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nsg_gate.sv
// Nearest point from mu and the elliptical gate test; last stage is the output register.
// Depends on nsg_pkg.
`default_nettype none

module nsg_gate (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  nsg_pkg::t_div_item  i_item,
    output logic                o_valid,
    output logic                o_near
);
    import nsg_pkg::*;

    logic [2:0]              r_v;
    logic signed [40:0]      r_p0;
    logic signed [40:0]      r_p1;
    t_veh                    r_a0;
    t_veh                    r_a1;
    logic [2:0]              r_kill;
    logic signed [NW-1:0]    r_n0;
    logic signed [NW-1:0]    r_n1;
    logic [49:0]             r_xs;
    logic [49:0]             r_ys;
    logic                    r_neg;
    logic [MUW-1:0]          mu;
    logic signed [40:0]      s0;
    logic signed [40:0]      s1;
    logic [63:0]             lhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[1:0], i_valid};
            o_valid <= r_v[2];
        end
    end

    always_comb begin
        mu  = i_item.full ? (MUW'(1) << MU_FRAC) : {1'b0, i_item.q};
        s0  = (r_p0 + 41'sd32768) >>> MU_FRAC;
        s1  = (r_p1 + 41'sd32768) >>> MU_FRAC;
        lhs = 64'(r_xs) * GATE_LAT2 + 64'(r_ys) * GATE_LONG2;
    end

    // Stage 1: tangent times mu; stage 2: nearest point;
    // stage 3: squares; stage 4: weighted compare
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0      <= i_item.t0 * $signed({1'b0, mu});
            r_p1      <= i_item.t1 * $signed({1'b0, mu});
            r_a0      <= i_item.a0;
            r_a1      <= i_item.a1;
            r_kill[0] <= i_item.degen;

            r_n0      <= NW'(r_a0) + s0[NW-1:0];
            r_n1      <= NW'(r_a1) + s1[NW-1:0];
            r_kill[1] <= r_kill[0];

            r_xs      <= 50'(r_n0) * 50'(r_n0);
            r_ys      <= 50'(r_n1) * 50'(r_n1);
            r_neg     <= r_n0[NW-1];
            r_kill[2] <= r_kill[1];

            o_near    <= !r_kill[2] && !r_neg && (lhs < GATE_RHS);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/near_segment_gate_core.sv
// Throughput: one request per cycle; the 16-stage mu divider and the four
// transform stages are fully pipelined, and a stalled output holds every stage.
// Reset: synchronous, active low; clears all valid bits and loads the identity
// pose (quaternion w = 1.0, all else zero).
// Depends on nsg_pkg, nsg_xform, nsg_proj, nsg_div and nsg_gate.
`default_nettype none

module near_segment_gate_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [2:0]       i_cfg_addr,
    input  wire  [31:0]      i_cfg_wdata,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire  signed [31:0] i_from_x,
    input  wire  signed [31:0] i_from_y,
    input  wire  signed [31:0] i_from_z,
    input  wire  signed [31:0] i_to_x,
    input  wire  signed [31:0] i_to_y,
    input  wire  signed [31:0] i_to_z,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output logic             o_is_near
);
    import nsg_pkg::*;

    t_quat      r_quat [4];
    t_coord     r_pos  [3];
    t_coord     from_v [3];
    t_coord     to_v   [3];
    logic       en;
    logic       x_valid;
    t_veh       x_a [3];
    t_veh       x_b [3];
    logic       p_valid;
    t_div_item  p_item;
    logic       d_valid;
    t_div_item  d_item;

    // The whole pipeline advances unless a finished result is held
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign from_v[0] = i_from_x;
    assign from_v[1] = i_from_y;
    assign from_v[2] = i_from_z;
    assign to_v[0]   = i_to_x;
    assign to_v[1]   = i_to_y;
    assign to_v[2]   = i_to_z;

    // Pose registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat[0] <= t_quat'(16384);
            r_quat[1] <= '0;
            r_quat[2] <= '0;
            r_quat[3] <= '0;
            r_pos[0]  <= '0;
            r_pos[1]  <= '0;
            r_pos[2]  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_QUAT_W: r_quat[0] <= i_cfg_wdata[QW-1:0];
                REG_QUAT_X: r_quat[1] <= i_cfg_wdata[QW-1:0];
                REG_QUAT_Y: r_quat[2] <= i_cfg_wdata[QW-1:0];
                REG_QUAT_Z: r_quat[3] <= i_cfg_wdata[QW-1:0];
                REG_POS_X:  r_pos[0]  <= i_cfg_wdata;
                REG_POS_Y:  r_pos[1]  <= i_cfg_wdata;
                REG_POS_Z:  r_pos[2]  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    nsg_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_from  (from_v),
        .i_to    (to_v),
        .i_quat  (r_quat),
        .i_pos   (r_pos),
        .o_valid (x_valid),
        .o_a     (x_a),
        .o_b     (x_b)
    );

    nsg_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (x_valid),
        .i_a     (x_a),
        .i_b     (x_b),
        .o_valid (p_valid),
        .o_item  (p_item)
    );

    nsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_item  (p_item),
        .o_valid (d_valid),
        .o_item  (d_item)
    );

    nsg_gate u_gate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_item  (d_item),
        .o_valid (o_out_valid),
        .o_near  (o_is_near)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for near_segment_gate_core: map segments are streamed under
// several poses and every gate decision is checked against an in-bench fixed-point predictor.
// Depends on nsg_pkg and the near_segment_gate_core RTL.

module tb;
    import nsg_pkg::*;

    // Predicts the gate decision and keeps the decisions still owed by the block.
    class gate_scoreboard;
        logic [15:0] quat [4];
        logic [31:0] pos [3];
        bit          owed [$];
        int          errors;

        function void reset_pose();
            quat[0] = 16'd16384;
            quat[1] = '0;
            quat[2] = '0;
            quat[3] = '0;
            foreach (pos[i]) pos[i] = '0;
        endfunction

        function void write_reg(int idx, logic [31:0] data);
            if (idx < 4) begin
                quat[idx] = data[15:0];
            end else if (idx < 7) begin
                pos[idx - 4] = data;
            end
        endfunction

        // Moves one map point into the vehicle frame, rounded to 2^-8 m and saturated.
        function void to_vehicle(longint rot [3][3], longint pt [3], output longint v [3]);
            longint d [3];
            longint acc;
            for (int i = 0; i < 3; i++) begin
                d[i] = pt[i] - longint'($signed(pos[i]));
            end
            for (int i = 0; i < 3; i++) begin
                acc = rot[0][i] * d[0] + rot[1][i] * d[1] + rot[2][i] * d[2];
                acc = (acc + (longint'(1) <<< (VEH_SHIFT - 1))) >>> VEH_SHIFT;
                if (acc > 2097151) acc = 2097151;
                if (acc < -2097151) acc = -2097151;
                v[i] = acc;
            end
        endfunction

        function bit near_gate(longint seg_from [3], longint seg_to [3]);
            longint w, x, y, z, one, tsq, inner, num, mu;
            longint e [3][3];
            longint rot [3][3];
            longint a [3];
            longint b [3];
            longint t [3];
            longint n [2];
            longint lhs, rhs;
            w = $signed(quat[0]);
            x = $signed(quat[1]);
            y = $signed(quat[2]);
            z = $signed(quat[3]);
            one = longint'(1) <<< 28;
            e[0][0] = one - 2 * (y * y + z * z);
            e[0][1] = 2 * (x * y - w * z);
            e[0][2] = 2 * (x * z + w * y);
            e[1][0] = 2 * (x * y + w * z);
            e[1][1] = one - 2 * (x * x + z * z);
            e[1][2] = 2 * (y * z - w * x);
            e[2][0] = 2 * (x * z - w * y);
            e[2][1] = 2 * (y * z + w * x);
            e[2][2] = one - 2 * (x * x + y * y);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    rot[i][j] = (e[i][j] + 8192) >>> QUAT_FRAC;
                end
            end
            to_vehicle(rot, seg_from, a);
            to_vehicle(rot, seg_to, b);
            tsq = 0;
            inner = 0;
            for (int i = 0; i < 3; i++) begin
                t[i] = b[i] - a[i];
                tsq += t[i] * t[i];
                inner += a[i] * t[i];
            end
            // Degenerate segment: squared length below 0.001 m^2.
            if (tsq * 1000 < (longint'(1) <<< (2 * VEH_FRAC))) return 1'b0;
            num = -inner;
            if (num <= 0) begin
                mu = 0;
            end else if (num >= tsq) begin
                mu = longint'(1) <<< MU_FRAC;
            end else begin
                mu = (num <<< MU_FRAC) / tsq;
            end
            for (int i = 0; i < 2; i++) begin
                n[i] = a[i] + ((t[i] * mu + (longint'(1) <<< (MU_FRAC - 1))) >>> MU_FRAC);
            end
            // Nearest point behind the vehicle.
            if (n[0] < 0) return 1'b0;
            lhs = n[0] * n[0] * 100 + n[1] * n[1] * 3600;
            rhs = longint'(360000) <<< (2 * VEH_FRAC);
            return lhs < rhs;
        endfunction

        function void note_request(longint seg_from [3], longint seg_to [3]);
            owed.insert(owed.size(), near_gate(seg_from, seg_to));
        endfunction

        function void check_result(logic is_near);
            bit want;
            if (owed.size() == 0) begin
                $error("unexpected result: is_near actual %0b", is_near);
                errors++;
            end else begin
                want = owed.pop_front();
                if (is_near !== want) begin
                    $error("is_near mismatch: expected %0b actual %0b", want, is_near);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic signed [31:0] i_from_x = '0, i_from_y = '0, i_from_z = '0;
    logic signed [31:0] i_to_x = '0, i_to_y = '0, i_to_z = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_is_near;

    gate_scoreboard gates = new();
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    near_segment_gate_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_from_x(i_from_x), .i_from_y(i_from_y), .i_from_z(i_from_z),
        .i_to_x(i_to_x), .i_to_y(i_to_y), .i_to_z(i_to_z),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_is_near(o_is_near)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            gates.check_result(o_is_near);
        end
    end

    // Writes one register; the caller drops the write enable after the last write.
    task automatic write_cfg(int idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= 3'(idx);
        i_cfg_wdata <= data;
        @(posedge i_clk);
        gates.write_reg(idx, data);
    endtask

    task automatic set_pose(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        write_cfg(REG_QUAT_W, {{16{w[15]}}, w});
        write_cfg(REG_QUAT_X, {{16{x[15]}}, x});
        write_cfg(REG_QUAT_Y, {{16{y[15]}}, y});
        write_cfg(REG_QUAT_Z, {{16{z[15]}}, z});
        write_cfg(REG_POS_X, px);
        write_cfg(REG_POS_Y, py);
        write_cfg(REG_POS_Z, pz);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one segment request and waits until it is accepted.
    task automatic send_segment(longint seg_from [3], longint seg_to [3]);
        i_from_x <= 32'(seg_from[0]);
        i_from_y <= 32'(seg_from[1]);
        i_from_z <= 32'(seg_from[2]);
        i_to_x <= 32'(seg_to[0]);
        i_to_y <= 32'(seg_to[1]);
        i_to_z <= 32'(seg_to[2]);
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        for (int i = 0; i < 3; i++) begin
            seg_from[i] = longint'($signed(32'(seg_from[i])));
            seg_to[i] = longint'($signed(32'(seg_to[i])));
        end
        gates.note_request(seg_from, seg_to);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_pair(longint fx, longint fy, longint fz,
                             longint tx, longint ty, longint tz);
        longint f [3];
        longint t [3];
        f = '{fx, fy, fz};
        t = '{tx, ty, tz};
        send_segment(f, t);
    endtask

    // Mostly segments around the vehicle, some tiny ones, some fully random.
    task automatic send_random();
        longint f [3];
        longint t [3];
        int kind;
        kind = $urandom_range(99);
        for (int i = 0; i < 3; i++) begin
            if (kind < 25) begin
                f[i] = $signed($urandom());
                t[i] = $signed($urandom());
            end else begin
                f[i] = longint'($signed(gates.pos[i])) + $signed($urandom_range(163840)) - 81920;
                if (kind < 35) begin
                    t[i] = f[i] + $signed($urandom_range(40)) - 20;
                end else begin
                    t[i] = f[i] + $signed($urandom_range(102400)) - 51200;
                end
            end
        end
        send_segment(f, t);
    endtask

    // Stops offering requests and waits until every owed result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (gates.owed.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        longint big;
        gates.reset_pose();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed segments under the reset pose.
        big = 64'sh7fffffff;
        send_pair(10240, -5120, 0, 10240, 5120, 0);         // crosses ahead: near
        send_pair(-10240, -5120, 0, -10240, 5120, 0);       // behind
        send_pair(10240, 0, 0, 10250, 0, 0);                // degenerate
        send_pair(0, 0, 0, 0, 0, 0);                        // zero length
        send_pair(70000, 0, 0, 80000, 0, 0);                // beyond the long axis
        send_pair(20480, 10000, 0, 30720, 12000, 0);        // beyond the lateral axis
        send_pair(61439, 0, 0, 61439, 10, 500);             // just inside along x; rounds onto the edge: not near
        send_pair(61441, -100, 0, 61441, 100, 0);           // just outside along x
        send_pair(0, -10241, 0, 0, 10241, 0);               // through the origin
        send_pair(-20480, 0, 0, 20480, 0, 0);               // from behind to ahead
        send_pair(big, big, big, -big - 1, -big - 1, -big - 1);
        send_pair(-big - 1, 0, big, big, 0, -big - 1);
        send_pair(big, big, big, big, big, big);
        send_pair(-big - 1, -big - 1, -big - 1, -big - 1, -big - 1, 0);
        send_pair(5120, 2048, 100000, 5120, -2048, -100000);
        send_pair(-1, -1, -1, 32'sh55555555, -32'sh2aaaaaab, 1);
        wait_drained();
        write_cfg(7, 32'hffffffff);                         // index past the list: ignored
        i_cfg_we <= 1'b0;

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            case (phase)
                0: set_pose(16'd16384, 0, 0, 0, 0, 0, 0);
                1: set_pose(0, 0, 0, 16'd16384, 32'd102400, -32'sd51200, 32'd2048);
                2: set_pose(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
                3: set_pose(16'd16384, 16'd16384, 16'd16384, 16'd16384,
                            32'h80000000, 32'h80000000, 32'h80000000);
                4: set_pose(16'd11585, 0, 0, 16'd11585, $urandom(), $urandom(), $urandom());
                5: set_pose(16'd15137, 16'd1000, -16'sd900, 16'd6270,
                            -32'sd40960, 32'd81920, 0);
                default: set_pose(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                  16'($urandom()), $urandom(), $urandom(), $urandom());
            endcase
            // Long receiver hold-off so that the pipeline fills and backs up.
            if (phase == 1) hold_left = 120;
            for (int k = 0; k < 135; k++) begin
                send_random();
            end
            wait_drained();
        end

        if (gates.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/nsg_pkg.sv
rtl/core/nsg_xform.sv
rtl/core/nsg_proj.sv
rtl/core/nsg_div.sv
rtl/core/nsg_gate.sv
rtl/core/near_segment_gate_core.sv
verif/tb.sv
